// ===== hw/rtl/nfe_pkg.sv =====
`timescale 1ns / 1ps

package nfe_pkg;

  // Fixed point format and field widths
  localparam int FRAC_BITS = 16;
  localparam int WORD_W    = 32;
  localparam int DT_W      = 31;
  localparam int MODE_W    = 4;

  // Product, scaled product and capped step widths
  localparam int PROD_W = 2 * WORD_W;
  localparam int SC_W   = PROD_W - FRAC_BITS;
  localparam int STEP_W = 34;
  localparam int SUM_W  = PROD_W + 1;
  localparam int SAT_W  = PROD_W + 2;

  // Divider dividend covers (|a - prev| << F) and the timer sum
  localparam int DIV_W     = (WORD_W + 1 + FRAC_BITS > SC_W) ? WORD_W + 1 + FRAC_BITS : SC_W;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);

  // Step cap for approach and integration: 2^33
  localparam logic [STEP_W-1:0] STEP_CAP = {1'b1, {(STEP_W - 1){1'b0}}};

  // Largest unusable divisor magnitude: 0.00001 in this format, which floors to zero
  localparam int RECIP_EPS = 100000;
  localparam logic [WORD_W-1:0] DIV_MIN = WORD_W'((1 << FRAC_BITS) / RECIP_EPS);

  localparam logic signed [WORD_W-1:0] ONE_Q    = WORD_W'(1 << FRAC_BITS);
  localparam logic signed [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W - 1){1'b1}}};
  localparam logic signed [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W - 1){1'b0}}};

  // Operation codes held in the mode register
  typedef enum logic [MODE_W-1:0] {
    OP_HOLD  = 4'd0,
    OP_ADD   = 4'd1,
    OP_SUB   = 4'd2,
    OP_MUL   = 4'd3,
    OP_DIV   = 4'd4,
    OP_LIN   = 4'd5,
    OP_PT1   = 4'd6,
    OP_INT   = 4'd7,
    OP_DERIV = 4'd8,
    OP_MOD   = 4'd9,
    OP_TIMER = 4'd10,
    OP_CMP   = 4'd11
  } op_t;

  // Divider request and response
  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [WORD_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_W-1:0]  quot;
    logic [WORD_W-1:0] rem;
  } div_rsp_t;

endpackage

// ===== hw/rtl/nfe_mul.sv =====
`timescale 1ns / 1ps

module nfe_mul (
  input  logic                         clk,
  input  logic [nfe_pkg::WORD_W-1:0]   x,
  input  logic [nfe_pkg::WORD_W-1:0]   y,
  output logic [nfe_pkg::PROD_W-1:0]   p
);
  import nfe_pkg::*;

  // Unsigned 32x32 product, registered
  always_ff @(posedge clk) begin
    p <= PROD_W'(x) * PROD_W'(y);
  end

endmodule

// ===== hw/rtl/nfe_div.sv =====
`timescale 1ns / 1ps

module nfe_div (
  input  logic              clk,
  input  logic              rst,
  input  nfe_pkg::div_req_t req,
  output nfe_pkg::div_rsp_t rsp
);
  import nfe_pkg::*;

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_W-1:0]     quo;
  logic [WORD_W-1:0]    rem;
  logic [WORD_W-1:0]    dvs;
  logic [WORD_W:0]      trial;
  logic [WORD_W+1:0]    sub;
  logic                 ge;

  // One restoring step: shift in next dividend bit, try the subtract
  assign trial = {rem, quo[DIV_W-1]};
  assign sub   = {1'b0, trial} - {2'b00, dvs};
  assign ge    = !sub[WORD_W+1];

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(DIV_W);
      end else if (busy) begin
        cnt <= cnt - DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: quotient bits replace dividend bits from the bottom
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      rem <= '0;
      dvs <= req.divisor;
    end else if (busy) begin
      quo <= {quo[DIV_W-2:0], ge};
      rem <= ge ? sub[WORD_W-1:0] : trial[WORD_W-1:0];
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quo;
  assign rsp.rem  = rem;

`ifndef NO_ASSERTIONS
  a_start_idle: assert property (@(posedge clk) disable iff (rst) req.start |-> !busy)
    else $error("divider started while busy");
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst) done |-> $past(busy))
    else $error("divider done without a running division");
  a_busy_count: assert property (@(posedge clk) disable iff (rst) busy |-> (cnt != '0))
    else $error("divider running with an empty step count");
`endif

endmodule

// ===== hw/rtl/numeric_function_element.sv =====
`timescale 1ns / 1ps

// Numeric function element, signed Q16.16.
// Input channel in_valid/in_ready carries in_a, in_b and step_time for one
// tick; output channel out_valid/out_ready returns result_value and held.
// The user writes the mode register via cfg_we/cfg_wdata only while no
// transaction is in flight; the block does not enforce this. Modes: hold,
// add, sub, mul, div, linear and first-order approach, integrate, derivative,
// modulo, timer or compare. Steps from input transaction to result valid:
//   hold, add, sub, mul, linear, compare, and held cases: issue, first, final
//   first-order approach, integrate: also low, high, scale (two extra
//   multiplier passes); div, derivative, modulo, timer: also divider start
//   and wait, while the one-bit-per-cycle divider runs.
// One item is worked at a time on the shared multiplier and divider; the
// next item is accepted in the cycle after a result is written.
// Reset: mode is hold, the kept result and previous operand are zero, no
// result is pending.
// If the receiver stalls, the next item is still accepted and worked, and
// waits at its final step until the pending result is taken.
module numeric_function_element (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [nfe_pkg::MODE_W-1:0]          cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [nfe_pkg::WORD_W-1:0]   in_a,
  input  logic signed [nfe_pkg::WORD_W-1:0]   in_b,
  input  logic [nfe_pkg::DT_W-1:0]            step_time,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [nfe_pkg::WORD_W-1:0]   result_value,
  output logic                                held
);
  import nfe_pkg::*;

  typedef enum logic [8:0] {
    ST_IDLE     = 9'b000000001,
    ST_ISSUE    = 9'b000000010,
    ST_FIRST    = 9'b000000100,
    ST_LO       = 9'b000001000,
    ST_HI       = 9'b000010000,
    ST_SCALE    = 9'b000100000,
    ST_DIV_GO   = 9'b001000000,
    ST_DIV_WAIT = 9'b010000000,
    ST_FIN      = 9'b100000000
  } state_t;

  function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [SAT_W-1:0] v);
    logic signed [SAT_W-1:0] hi;
    logic signed [SAT_W-1:0] lo;
    hi = SAT_W'(WORD_MAX);
    lo = SAT_W'(WORD_MIN);
    if (v > hi) return WORD_MAX;
    else if (v < lo) return WORD_MIN;
    else return $signed(v[WORD_W-1:0]);
  endfunction

  function automatic logic signed [SAT_W-1:0] sign_mag(input logic [SAT_W-2:0] m,
                                                       input logic neg);
    logic signed [SAT_W-1:0] s;
    s = $signed({1'b0, m});
    return neg ? -s : s;
  endfunction

  state_t                   state;
  state_t                   state_next;
  op_t                      mode;
  op_t                      op_r;
  logic signed [WORD_W-1:0] out_reg;
  logic signed [WORD_W-1:0] prev_a;
  logic signed [WORD_W-1:0] a_r;
  logic signed [WORD_W-1:0] b_r;
  logic [DT_W-1:0]          dt_r;
  logic [WORD_W-1:0]        mag_a;
  logic [WORD_W-1:0]        mag_b;
  logic [WORD_W-1:0]        mag_d;
  logic                     diff_neg;
  logic [SC_W-1:0]          x_r;
  logic [PROD_W-1:0]        p_lo;
  logic [STEP_W-1:0]        step_r;
  logic                     x_neg;

  logic                     accept;
  logic                     fin_write;
  logic                     a_neg;
  logic                     b_neg;
  logic                     b_zero;
  logic                     b_pos;
  logic                     div_small;
  logic                     dt_zero;
  logic                     lin_mode;
  logic signed [WORD_W-1:0] diff_base;
  logic signed [WORD_W:0]   in_diff;
  logic [WORD_W-1:0]        y_scale;
  logic [WORD_W-1:0]        mul_x;
  logic [WORD_W-1:0]        mul_y;
  logic [PROD_W-1:0]        mul_p;
  logic [SUM_W-1:0]         sc_sum;
  logic [SUM_W-1:0]         sc_shift;
  logic                     sc_big;
  logic [STEP_W-1:0]        sc_step;
  logic [STEP_W-1:0]        lin_step;
  logic [STEP_W-1:0]        appr_step;
  logic signed [SC_W+1:0]   tm_x;
  logic [SC_W+1:0]          tm_mag;
  logic signed [WORD_W-1:0] rem_s;
  logic signed [WORD_W-1:0] r_next;
  logic                     held_next;
  div_req_t                 div_req;
  div_rsp_t                 div_rsp;

  // Handshake
  assign in_ready     = (state == ST_IDLE);
  assign accept       = in_valid && in_ready;
  assign fin_write    = (state == ST_FIN) && (!out_valid || out_ready);
  assign result_value = out_reg;

  // Operand flags
  assign a_neg     = a_r[WORD_W-1];
  assign b_neg     = b_r[WORD_W-1];
  assign b_zero    = (b_r == '0);
  assign b_pos     = !b_neg && !b_zero;
  assign div_small = (mag_b <= DIV_MIN);
  assign dt_zero   = (dt_r == '0);
  assign lin_mode  = (op_r == OP_LIN) || (op_r == OP_PT1);

  // Difference at accept: against prev_a for derivative, else the kept result
  assign diff_base = (mode == OP_DERIV) ? prev_a : out_reg;
  assign in_diff   = (WORD_W + 1)'(in_a) - (WORD_W + 1)'(diff_base);

  // Multiplier operand select
  assign y_scale = (op_r == OP_PT1) ? mag_d : WORD_W'(dt_r);

  always_comb begin
    priority if (state == ST_LO) begin
      mul_x = x_r[WORD_W-1:0];
      mul_y = y_scale;
    end else if (state == ST_HI) begin
      mul_x = WORD_W'(x_r[SC_W-1:WORD_W]);
      mul_y = y_scale;
    end else begin
      mul_x = lin_mode ? WORD_W'(dt_r) : mag_a;
      mul_y = (op_r == OP_TIMER) ? WORD_W'(dt_r) : mag_b;
    end
  end

  nfe_mul u_mul (
    .clk (clk),
    .x   (mul_x),
    .y   (mul_y),
    .p   (mul_p)
  );

  // Scale a 48-bit value by 32 bits from low and high partial products, capped
  assign sc_sum   = SUM_W'({mul_p[FRAC_BITS:0], {WORD_W{1'b0}}}) + SUM_W'(p_lo);
  assign sc_shift = sc_sum >> FRAC_BITS;
  assign sc_big   = |mul_p[PROD_W-1:FRAC_BITS+1];
  assign sc_step  = (sc_big || (sc_shift >= SUM_W'(STEP_CAP))) ? STEP_CAP
                                                                : sc_shift[STEP_W-1:0];

  // Linear approach step: k capped
  assign lin_step  = (x_r > SC_W'(STEP_CAP)) ? STEP_CAP : x_r[STEP_W-1:0];
  assign appr_step = (op_r == OP_LIN) ? lin_step : step_r;

  // Timer sum before modulo
  assign tm_x   = (SC_W + 2)'(out_reg)
                + (a_neg ? -$signed({2'b00, x_r}) : $signed({2'b00, x_r}));
  assign tm_mag = tm_x[SC_W+1] ? -tm_x : tm_x;

  // Divider request
  always_comb begin
    div_req.start = (state == ST_DIV_GO);
    unique case (op_r)
      OP_DIV: begin
        div_req.dividend = DIV_W'({mag_a, {FRAC_BITS{1'b0}}});
        div_req.divisor  = mag_b;
      end
      OP_DERIV: begin
        div_req.dividend = DIV_W'({mag_d, {FRAC_BITS{1'b0}}});
        div_req.divisor  = WORD_W'(dt_r);
      end
      OP_TIMER: begin
        div_req.dividend = DIV_W'(tm_mag[SC_W-1:0]);
        div_req.divisor  = mag_b;
      end
      default: begin
        div_req.dividend = DIV_W'(mag_a);
        div_req.divisor  = mag_b;
      end
    endcase
  end

  nfe_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign rem_s = $signed(div_rsp.rem);

  // Result of the finished item
  always_comb begin
    r_next    = out_reg;
    held_next = 1'b0;
    unique case (op_r)
      OP_ADD: r_next = sat_word(SAT_W'(a_r) + SAT_W'(b_r));
      OP_SUB: r_next = sat_word(SAT_W'(a_r) - SAT_W'(b_r));
      OP_MUL: r_next = sat_word(sign_mag((SAT_W - 1)'(x_r), a_neg ^ b_neg));
      OP_DIV: begin
        if (div_small) held_next = 1'b1;
        else r_next = sat_word(sign_mag((SAT_W - 1)'(div_rsp.quot), a_neg ^ b_neg));
      end
      OP_LIN, OP_PT1: begin
        if (b_pos && (STEP_W'(mag_d) < appr_step)) r_next = a_r;
        else r_next = sat_word(SAT_W'(out_reg)
                               + sign_mag((SAT_W - 1)'(appr_step), diff_neg));
      end
      OP_INT: r_next = sat_word(SAT_W'(out_reg)
                                + sign_mag((SAT_W - 1)'(step_r), a_neg ^ b_neg));
      OP_DERIV: begin
        if (dt_zero) held_next = 1'b1;
        else r_next = sat_word(sign_mag((SAT_W - 1)'(div_rsp.quot), diff_neg));
      end
      OP_MOD: begin
        if (b_zero) held_next = 1'b1;
        else r_next = a_neg ? -rem_s : rem_s;
      end
      OP_TIMER: begin
        if (b_zero) held_next = 1'b1;
        else r_next = x_neg ? -rem_s : rem_s;
      end
      OP_CMP: r_next = (a_r > b_r) ? ONE_Q : '0;
      default: r_next = out_reg;
    endcase
  end

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (accept) state_next = ST_ISSUE;
      ST_ISSUE: state_next = ST_FIRST;
      ST_FIRST: begin
        unique case (op_r)
          OP_PT1, OP_INT:   state_next = ST_LO;
          OP_DIV:           state_next = div_small ? ST_FIN : ST_DIV_GO;
          OP_DERIV:         state_next = dt_zero ? ST_FIN : ST_DIV_GO;
          OP_MOD, OP_TIMER: state_next = b_zero ? ST_FIN : ST_DIV_GO;
          default:          state_next = ST_FIN;
        endcase
      end
      ST_LO:       state_next = ST_HI;
      ST_HI:       state_next = ST_SCALE;
      ST_SCALE:    state_next = ST_FIN;
      ST_DIV_GO:   state_next = ST_DIV_WAIT;
      ST_DIV_WAIT: if (div_rsp.done) state_next = ST_FIN;
      ST_FIN:      if (fin_write) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // Control and kept state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      mode      <= OP_HOLD;
      out_reg   <= '0;
      prev_a    <= '0;
      out_valid <= 1'b0;
      held      <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) mode <= op_t'(cfg_wdata);
      if (accept && (mode == OP_DERIV)) prev_a <= in_a;
      if (fin_write) begin
        out_reg   <= r_next;
        held      <= held_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Working registers of the current item
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r     <= mode;
      a_r      <= in_a;
      b_r      <= in_b;
      dt_r     <= step_time;
      mag_a    <= in_a[WORD_W-1] ? WORD_W'(-in_a) : WORD_W'(in_a);
      mag_b    <= in_b[WORD_W-1] ? WORD_W'(-in_b) : WORD_W'(in_b);
      mag_d    <= in_diff[WORD_W] ? WORD_W'(-in_diff) : in_diff[WORD_W-1:0];
      diff_neg <= in_diff[WORD_W];
    end
    if (state == ST_FIRST) x_r <= mul_p[PROD_W-1:FRAC_BITS];
    if (state == ST_HI) p_lo <= mul_p;
    if (state == ST_SCALE) step_r <= sc_step;
    if (state == ST_DIV_GO) x_neg <= tm_x[SC_W+1];
  end

`ifndef NO_ASSERTIONS
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    !fin_write |=> $stable(out_reg))
    else $error("kept result changed outside the final step");
  a_div_waited: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == ST_DIV_WAIT))
    else $error("divider finished while not waited for");
  a_prev_stable: assert property (@(posedge clk) disable iff (rst)
    !(accept && (mode == OP_DERIV)) |=> $stable(prev_a))
    else $error("previous operand changed outside a derivative transaction");
`endif

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import nfe_pkg::*;

  typedef longint unsigned u64_t;

  localparam int     FRAC       = FRAC_BITS;
  localparam u64_t   STEP_LIMIT = 64'd1 << 33;
  localparam u64_t   SCALE_LIM  = 64'd1 << (33 + FRAC);
  localparam u64_t   DIV_FLOOR  = (64'd1 << FRAC) / RECIP_EPS;
  localparam longint Q_MAX      = 64'sh7FFF_FFFF;
  localparam longint Q_MIN      = -64'sh8000_0000;
  localparam int     RANDOM_TICKS = 1950;
  localparam int     QUIET_FROM   = 1650;

  // Highest mode code; codes above compare are unused and keep the result
  localparam logic [MODE_W-1:0] MODE_SPARE = 4'd15;

  // Q16.16 constants used by the directed ticks
  localparam logic [WORD_W-1:0] Q_ONE   = 32'h0001_0000;
  localparam logic [WORD_W-1:0] Q_M_ONE = 32'hFFFF_0000;
  localparam logic [WORD_W-1:0] Q_THREE = 32'h0003_0000;
  localparam logic [WORD_W-1:0] Q_FIVE  = 32'h0005_0000;
  localparam logic [WORD_W-1:0] Q_HALF  = 32'h0000_8000;
  localparam logic [WORD_W-1:0] W_MAX   = 32'h7FFF_FFFF;
  localparam logic [WORD_W-1:0] W_MIN   = 32'h8000_0000;
  localparam logic [DT_W-1:0]   DT_MAX  = 31'h7FFF_FFFF;

  typedef struct {
    logic signed [WORD_W-1:0] value;
    logic                     held;
  } tick_result_t;

  // Tracks the element's state and the results still owed by the block
  class result_tracker;
    logic [MODE_W-1:0] mode;
    longint            kept_out;
    longint            kept_prev;
    tick_result_t      awaited[$];
    int                errors;

    function new();
      mode      = OP_HOLD;
      kept_out  = 0;
      kept_prev = 0;
      errors    = 0;
    endfunction

    function longint sat_word(longint v);
      if (v > Q_MAX) return Q_MAX;
      if (v < Q_MIN) return Q_MIN;
      return v;
    endfunction

    function u64_t mag(longint v);
      return (v < 0) ? $unsigned(-v) : $unsigned(v);
    endfunction

    function longint with_sign(u64_t m, bit neg);
      longint s;
      s = $signed(m);
      return neg ? -s : s;
    endfunction

    // floor(m*d >> FRAC), capped at the step limit
    function u64_t scale_capped(u64_t m, u64_t d);
      if (d == 0) return 0;
      if (m > SCALE_LIM / d) return STEP_LIMIT;
      return (m * d) >> FRAC;
    endfunction

    // Work out the result of one accepted tick and queue it
    function void accept_tick(logic signed [WORD_W-1:0] a_in, logic signed [WORD_W-1:0] b_in,
                              logic [DT_W-1:0] dt_in);
      longint       a, b, r, diff, x;
      u64_t         dt, d, k, stp, m;
      bit           hd;
      tick_result_t e;
      a  = a_in;
      b  = b_in;
      dt = dt_in;
      r  = kept_out;
      hd = 0;
      case (mode)
        OP_ADD: r = sat_word(a + b);
        OP_SUB: r = sat_word(a - b);
        OP_MUL: r = sat_word(with_sign((mag(a) * mag(b)) >> FRAC, (a < 0) != (b < 0)));
        OP_DIV: begin
          if (mag(b) <= DIV_FLOOR) hd = 1;
          else r = sat_word((a <<< FRAC) / b);
        end
        OP_LIN, OP_PT1: begin
          diff = a - kept_out;
          d    = mag(diff);
          k    = (dt * mag(b)) >> FRAC;
          if (mode == OP_PT1) stp = scale_capped(k, d);
          else stp = (k > STEP_LIMIT) ? STEP_LIMIT : k;
          // positive rate snaps onto the target when the step would pass it
          if (b > 0 && d < stp) r = a;
          else r = sat_word(kept_out + with_sign(stp, diff < 0));
        end
        OP_INT: begin
          m = scale_capped((mag(a) * mag(b)) >> FRAC, dt);
          r = sat_word(kept_out + with_sign(m, (a < 0) != (b < 0)));
        end
        OP_DERIV: begin
          if (dt == 0) hd = 1;
          else r = sat_word(((a - kept_prev) <<< FRAC) / longint'(dt));
          kept_prev = a;
        end
        OP_MOD: begin
          if (b == 0) hd = 1;
          else r = a % b;
        end
        OP_TIMER: begin
          if (b == 0) begin
            hd = 1;
          end else begin
            x = kept_out + with_sign((mag(a) * dt) >> FRAC, a < 0);
            r = x % b;
          end
        end
        OP_CMP: r = (a > b) ? (64'sd1 <<< FRAC) : 0;
        default: ;
      endcase
      kept_out = r;
      e.value  = r[WORD_W-1:0];
      e.held   = hd;
      awaited.push_back(e);
    endfunction

    // Compare one result transaction with the oldest expectation
    function void check_result(logic signed [WORD_W-1:0] val, logic hd);
      tick_result_t e;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t: result expected none actual value %h held %b", $time, val, hd);
        return;
      end
      e = awaited.pop_front();
      if (val !== e.value) begin
        errors++;
        $display("%0t: result_value expected %h actual %h", $time, e.value, val);
      end
      if (hd !== e.held) begin
        errors++;
        $display("%0t: held expected %b actual %b", $time, e.held, hd);
      end
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_we = 1'b0;
  logic [MODE_W-1:0]        cfg_wdata = '0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic signed [WORD_W-1:0] in_a = '0;
  logic signed [WORD_W-1:0] in_b = '0;
  logic [DT_W-1:0]          step_time = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b1;
  logic signed [WORD_W-1:0] result_value;
  logic                     held;

  result_tracker tracker = new();
  bit            send_idle = 1'b0;
  bit            recv_idle = 1'b0;
  int            stall_left = 0;

  numeric_function_element dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_a         (in_a),
    .in_b         (in_b),
    .step_time    (step_time),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_value (result_value),
    .held         (held)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Watch both channels; results are checked before the new tick is queued
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) tracker.check_result(result_value, held);
      if (in_valid && in_ready) tracker.accept_tick(in_a, in_b, step_time);
    end
  end

  // Receiver: random stall bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_ready  = 1'b0;
    end else if (recv_idle && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(1, 8) - 1;
      out_ready  = 1'b0;
    end else begin
      out_ready = 1'b1;
    end
  end

  // Offer one tick, with an optional idle burst first; returns at the falling
  // edge after acceptance with valid still high
  task automatic send_tick(logic [WORD_W-1:0] a, logic [WORD_W-1:0] b, logic [DT_W-1:0] dt);
    if (send_idle && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_valid  = 1'b1;
    in_a      = a;
    in_b      = b;
    step_time = dt;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Stop sending and wait until every owed result has been taken
  task automatic wait_drained();
    in_valid = 1'b0;
    while (tracker.awaited.size() != 0) @(negedge clk);
  endtask

  // Mode changes only once the block is idle
  task automatic set_mode(logic [MODE_W-1:0] m);
    wait_drained();
    cfg_we        = 1'b1;
    cfg_wdata     = m;
    tracker.mode  = m;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic directed_tick(logic [MODE_W-1:0] m, logic [WORD_W-1:0] a,
                               logic [WORD_W-1:0] b, logic [DT_W-1:0] dt);
    if (m != tracker.mode) set_mode(m);
    send_tick(a, b, dt);
  endtask

  // Operand mix: extremes, unit values, small values and full random words
  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return W_MAX;
      2:       return W_MIN;
      3:       return $urandom_range(0, 1) ? Q_ONE : Q_M_ONE;
      4, 5:    return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
      6:       return $urandom_range(0, 6) - 3;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [DT_W-1:0] pick_dt();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return DT_MAX;
      2, 3, 4: return DT_W'($urandom_range(1, 32'h0000_4000));
      5:       return DT_W'($urandom_range(1, 32'h0004_0000));
      default: return DT_W'($urandom());
    endcase
  endfunction

  initial begin
    logic [MODE_W-1:0] m;
    logic [WORD_W-1:0] target, a;
    int                sent, phase_len;

    repeat (6) @(negedge clk);
    rst = 1'b0;

    // Directed ticks: field extremes, each operation and the hold cases
    directed_tick(OP_HOLD,  32'h1234_5678, '0, 31'd5);
    directed_tick(OP_ADD,   W_MAX, W_MAX, '0);
    directed_tick(OP_ADD,   W_MIN, W_MIN, DT_MAX);
    directed_tick(OP_SUB,   W_MAX, W_MIN, 31'd1);
    directed_tick(OP_MUL,   W_MIN, W_MIN, '0);
    directed_tick(OP_MUL,   W_MAX, Q_M_ONE, '0);
    directed_tick(OP_DIV,   Q_ONE, '0, '0);
    directed_tick(OP_DIV,   W_MIN, 32'd1, '0);
    directed_tick(OP_DIV,   Q_THREE, Q_M_ONE, '0);
    directed_tick(OP_LIN,   W_MAX, W_MAX, DT_MAX);
    directed_tick(OP_LIN,   W_MIN, Q_M_ONE, 31'h0001_0000);
    directed_tick(OP_PT1,   W_MIN, W_MAX, DT_MAX);
    directed_tick(OP_PT1,   '0, Q_ONE, 31'h0000_8000);
    directed_tick(OP_INT,   W_MAX, W_MAX, DT_MAX);
    directed_tick(OP_INT,   W_MIN, W_MAX, 31'h0001_0000);
    directed_tick(OP_DERIV, Q_FIVE, Q_HALF, '0);
    directed_tick(OP_DERIV, W_MIN, '0, 31'd1);
    directed_tick(OP_DERIV, W_MAX, '0, DT_MAX);
    directed_tick(OP_MOD,   Q_THREE, '0, '0);
    directed_tick(OP_MOD,   W_MIN, 32'hFFFF_FFFF, '0);
    directed_tick(OP_TIMER, Q_ONE, '0, 31'h0001_0000);
    directed_tick(OP_TIMER, W_MAX, Q_THREE, DT_MAX);
    directed_tick(OP_CMP,   W_MAX, W_MIN, '0);
    directed_tick(OP_CMP,   Q_ONE, Q_ONE, '0);
    directed_tick(MODE_SPARE, 32'd1, 32'd2, 31'd3);

    // Random phases, one mode each; every phase starts from an idle block
    sent = 0;
    while (sent < RANDOM_TICKS) begin
      if ($urandom_range(0, 9) == 0) begin
        m = MODE_W'($urandom_range(OP_CMP, MODE_SPARE));
        if (m == OP_CMP) m = OP_HOLD;
      end else begin
        m = MODE_W'($urandom_range(OP_ADD, OP_CMP));
      end
      set_mode(m);
      if (sent >= QUIET_FROM) begin
        send_idle = 1'b0;
        recv_idle = 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        send_idle = 1'b0;
        recv_idle = 1'b0;
      end else begin
        send_idle = $urandom_range(0, 1);
        recv_idle = $urandom_range(0, 1);
      end
      // a steady target lets approach, integrate and timer build up state
      target    = pick_word();
      phase_len = $urandom_range(20, 80);
      repeat (phase_len) begin
        a = ($urandom_range(0, 1) == 0) ? target : pick_word();
        send_tick(a, pick_word(), pick_dt());
      end
      sent += phase_len;
    end

    // Drain, then allow one full divide latency for stray results
    wait_drained();
    repeat (DIV_W + 10) @(negedge clk);
    if (tracker.errors == 0 && tracker.awaited.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Run limit
  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/nfe_pkg.sv
hw/rtl/nfe_mul.sv
hw/rtl/nfe_div.sv
hw/rtl/numeric_function_element.sv
test/testbench.sv
